FILE: rtl/dual_moving_average_crossover_assert.svh
// Assertion macros for the moving average crossover block.
// Included by the top level; no other dependencies.
`ifndef DUAL_MOVING_AVERAGE_CROSSOVER_ASSERT_SVH
`define DUAL_MOVING_AVERAGE_CROSSOVER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define DMAC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmac assertion failed");
// Next-cycle implication, checked outside reset.
`define DMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmac assertion failed");
`else
`define DMAC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/dmac_pkg.sv
// Shared types, constants and width helpers for the moving average crossover block.
// No dependencies.
`timescale 1ns / 1ps

package dmac_pkg;

    localparam int DEF_NUM_INSTRUMENTS = 16;
    localparam int DEF_MAX_WINDOW      = 64;

    // configuration register indexes
    localparam logic [1:0] REG_FAST_WINDOW = 2'd0;
    localparam logic [1:0] REG_SLOW_WINDOW = 2'd1;
    localparam logic [1:0] REG_SLIPPAGE    = 2'd2;

    localparam logic [5:0]  FAST_WINDOW_RESET = 6'd5;
    localparam logic [6:0]  SLOW_WINDOW_RESET = 7'd20;
    localparam logic [15:0] SLIPPAGE_RESET    = 16'd0;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // position codes, two's complement
    localparam logic [1:0] POS_FLAT    = 2'b00;
    localparam logic [1:0] POS_LONG    = 2'b01;
    localparam logic [1:0] POS_SHORT   = 2'b11;
    localparam logic [1:0] POS_UNUSED  = 2'b10;

    typedef struct packed {
        logic [3:0]  instrument;
        logic [31:0] close_price;
    } bar_t;

    typedef struct packed {
        logic [3:0]  order_instrument;
        logic        side;
        logic [31:0] limit_price;
    } order_t;

    // sequencer controls for the shared arithmetic unit
    typedef struct packed {
        logic clr_acc;
        logic acc_en;
        logic cap_fast;
        logic mul_fast;
        logic mul_slow;
    } arith_ctrl_t;

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int ptr_width(input int m);
        return $clog2(m);
    endfunction

    function automatic int win_width(input int m);
        return $clog2(m + 1);
    endfunction

endpackage

FILE: rtl/dual_moving_average_crossover.sv
// Dual moving average crossover: a buy or sell order when the fast and slow means cross.
// Top level with sequencer; uses dmac_pkg, dmac_hist_mem, dmac_chan_tbl, dmac_arith.
//
// Usage:
//  - bar channel (bar_valid/bar_ready/bar) takes one request per bar: instrument index
//    and closing price. bar_ready is high only while the sequencer is idle.
//  - order channel (order_valid/order_ready/order) carries zero or one order per bar.
//    The order sits in an output register; the block takes the next bar while an
//    order waits, but a full-window bar stalls at its decision until the first leaves.
//  - cfg_we/cfg_addr/cfg_wdata write fast_window, slow_window and slippage; write
//    them only while idle. Writes to other indexes are dropped.
// Sequence, with S the effective slow window:
//  - instrument out of range: dropped in the accept cycle; the sequencer stays idle.
//  - window not yet full: load and update steps, then back to idle, no order.
//  - full window: the shared adder reads one stored price a cycle over S prices, behind
//    the registered memory read, then two multiply steps; the decision step registers
//    any order and returns to idle, waiting while an earlier order is still held.
//    The single-port history read sets the length of the summing loop.
// Reset: clears positions, fill counts and pointers through per-channel valid bits and
//  loads register defaults (5, 20, 0). History is only read once written.
`timescale 1ns / 1ps

module dual_moving_average_crossover #(
    parameter int NUM_INSTRUMENTS = dmac_pkg::DEF_NUM_INSTRUMENTS,
    parameter int MAX_WINDOW      = dmac_pkg::DEF_MAX_WINDOW
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             bar_valid,
    output logic             bar_ready,
    input  dmac_pkg::bar_t   bar,
    output logic             order_valid,
    input  logic             order_ready,
    output dmac_pkg::order_t order,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [15:0]      cfg_wdata
);
    import dmac_pkg::*;

`include "dual_moving_average_crossover_assert.svh"

    localparam int IDX_W = idx_width(NUM_INSTRUMENTS);
    localparam int PTR_W = ptr_width(MAX_WINDOW);
    localparam int WIN_W = win_width(MAX_WINDOW);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_MUL_L  = 3'd4;
    localparam logic [2:0] ST_MUL_R  = 3'd5;
    localparam logic [2:0] ST_DECIDE = 3'd6;

    logic [2:0]  state_reg, state_next;

    // configuration registers
    logic [5:0]  fast_reg;
    logic [6:0]  slow_reg;
    logic [15:0] slip_reg;

    // the bar being worked on
    logic [3:0]  inst_reg;
    logic [31:0] close_reg;
    logic [31:0] inst_wide;
    logic [IDX_W-1:0] idx;
    logic        accept;
    logic        inst_ok;

    // effective windows and per-bar bookkeeping
    logic [31:0]      f1, s1, s_eff, f_eff;
    logic [WIN_W-1:0] f_win_reg, s_win_reg;
    logic [WIN_W-1:0] fill_new, fill_new_reg;
    logic [PTR_W-1:0] wp_new, wp_new_reg;
    logic [1:0]       pos_reg;
    logic [PTR_W-1:0] slot_reg;
    logic [WIN_W-1:0] rd_cnt_reg, acc_cnt_reg;
    logic [WIN_W-1:0] acc_cnt_inc;
    logic             pend_reg;
    logic             issue;
    logic             short_path;

    // channel table and history
    logic [WIN_W-1:0] ch_fill;
    logic [PTR_W-1:0] ch_wp;
    logic [1:0]       ch_pos;
    logic             ch_we;
    logic [WIN_W-1:0] ch_wfill;
    logic [PTR_W-1:0] ch_wwp;
    logic [1:0]       ch_wpos;
    logic             hist_we;
    logic [31:0]      hist_rdata;

    // arithmetic unit
    arith_ctrl_t      actrl;
    logic             fast_above, fast_below;

    // decision and output register
    logic             go_decide;
    logic             buy, sell;
    logic [32:0]      buy_sum;
    logic [31:0]      buy_price, sell_price;
    logic             order_valid_reg;
    order_t           order_reg;

    // assertion terms
    logic             win_ok;
    logic             hold_empty;

    assign bar_ready = (state_reg == ST_IDLE);
    assign accept    = bar_valid && bar_ready;
    assign inst_ok   = 32'(bar.instrument) < 32'(NUM_INSTRUMENTS);
    assign inst_wide = 32'(inst_reg);
    assign idx       = inst_wide[IDX_W-1:0];

    // Config writes: drop unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg <= FAST_WINDOW_RESET;
            slow_reg <= SLOW_WINDOW_RESET;
            slip_reg <= SLIPPAGE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FAST_WINDOW: fast_reg <= cfg_wdata[5:0];
                REG_SLOW_WINDOW: slow_reg <= cfg_wdata[6:0];
                REG_SLIPPAGE:    slip_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Effective windows: fast at least one, slow not below fast, slow capped at the ring size.
    always_comb
    begin
        f1    = (fast_reg == 6'd0) ? 32'd1 : 32'(fast_reg);
        s1    = (32'(slow_reg) < f1) ? f1 + 32'd1 : 32'(slow_reg);
        s_eff = (s1 > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : s1;
        f_eff = (f1 > s_eff) ? s_eff : f1;
    end

    // Advance the ring pointer and the saturating fill count of the channel.
    assign fill_new   = (ch_fill < WIN_W'(MAX_WINDOW)) ? ch_fill + WIN_W'(1) : ch_fill;
    assign wp_new     = (ch_wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : ch_wp + PTR_W'(1);
    assign short_path = fill_new < s_eff[WIN_W-1:0];

    // Summation loop: issue reads newest first, accumulate in the cycle after each read.
    assign issue       = (state_reg == ST_SUM) && (rd_cnt_reg < s_win_reg);
    assign acc_cnt_inc = acc_cnt_reg + WIN_W'(1);

    assign go_decide  = (state_reg == ST_DECIDE) && (!order_valid_reg || order_ready);
    assign buy        = fast_above && (pos_reg != POS_LONG);
    assign sell       = fast_below && (pos_reg != POS_SHORT);
    assign buy_sum    = {1'b0, close_reg} + {17'd0, slip_reg};
    assign buy_price  = buy_sum[32] ? 32'hFFFF_FFFF : buy_sum[31:0];
    assign sell_price = (close_reg >= 32'(slip_reg)) ? close_reg - 32'(slip_reg) : 32'd0;

    always_comb
    begin
        state_next     = state_reg;
        actrl          = '0;
        hist_we        = 1'b0;
        ch_we          = 1'b0;
        ch_wfill       = fill_new;
        ch_wwp         = wp_new;
        ch_wpos        = ch_pos;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && inst_ok)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                hist_we       = 1'b1;
                actrl.clr_acc = 1'b1;
                if (short_path)
                begin
                    ch_we      = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                actrl.acc_en   = pend_reg;
                actrl.cap_fast = pend_reg && (acc_cnt_inc == f_win_reg);
                if (pend_reg && (acc_cnt_inc == s_win_reg))
                begin
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                actrl.mul_fast = 1'b1;
                state_next     = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                actrl.mul_slow = 1'b1;
                state_next     = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                ch_wfill = fill_new_reg;
                ch_wwp   = wp_new_reg;
                ch_wpos  = buy ? pos_reg + 2'd1 : (sell ? pos_reg - 2'd1 : pos_reg);
                if (go_decide)
                begin
                    ch_we      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pend_reg        <= 1'b0;
            rd_cnt_reg      <= '0;
            acc_cnt_reg     <= '0;
            order_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (state_reg == ST_UPDATE)
            begin
                rd_cnt_reg  <= '0;
                acc_cnt_reg <= '0;
            end
            else
            begin
                if (issue)
                begin
                    rd_cnt_reg <= rd_cnt_reg + WIN_W'(1);
                end
                if (actrl.acc_en)
                begin
                    acc_cnt_reg <= acc_cnt_inc;
                end
            end
            // hold the order until taken; load a new one on a crossing
            if (go_decide && (buy || sell))
            begin
                order_valid_reg <= 1'b1;
            end
            else if (order_ready)
            begin
                order_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && inst_ok)
        begin
            inst_reg  <= bar.instrument;
            close_reg <= bar.close_price;
        end
        if (state_reg == ST_UPDATE)
        begin
            f_win_reg    <= f_eff[WIN_W-1:0];
            s_win_reg    <= s_eff[WIN_W-1:0];
            fill_new_reg <= fill_new;
            wp_new_reg   <= wp_new;
            pos_reg      <= ch_pos;
            slot_reg     <= ch_wp;
        end
        else if (issue)
        begin
            slot_reg <= (slot_reg == '0) ? PTR_W'(MAX_WINDOW - 1) : slot_reg - PTR_W'(1);
        end
        if (go_decide && (buy || sell))
        begin
            order_reg.order_instrument <= inst_reg;
            order_reg.side             <= buy ? SIDE_BUY : SIDE_SELL;
            order_reg.limit_price      <= buy ? buy_price : sell_price;
        end
    end

    assign order_valid = order_valid_reg;
    assign order       = order_reg;

    dmac_hist_mem #(
        .NUM_INSTRUMENTS (NUM_INSTRUMENTS),
        .MAX_WINDOW      (MAX_WINDOW)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr ({idx, ch_wp}),
        .wdata (close_reg),
        .raddr ({idx, slot_reg}),
        .rdata (hist_rdata)
    );

    dmac_chan_tbl #(
        .NUM_INSTRUMENTS (NUM_INSTRUMENTS),
        .MAX_WINDOW      (MAX_WINDOW)
    ) u_chan (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (idx),
        .rd_fill (ch_fill),
        .rd_wp   (ch_wp),
        .rd_pos  (ch_pos),
        .wr_en   (ch_we),
        .wr_idx  (idx),
        .wr_fill (ch_wfill),
        .wr_wp   (ch_wwp),
        .wr_pos  (ch_wpos)
    );

    dmac_arith #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_arith (
        .clk        (clk),
        .ctrl       (actrl),
        .price      (hist_rdata),
        .f_win      (f_win_reg),
        .s_win      (s_win_reg),
        .fast_above (fast_above),
        .fast_below (fast_below)
    );

    assign win_ok     = (f_win_reg != '0) && (f_win_reg <= s_win_reg);
    assign hold_empty = !order_valid_reg && (state_reg != ST_DECIDE);

    // Loop never reads past the slow window, and windows stay ordered.
    `DMAC_ASSERT_SAME(a_rd_bound, clk, rst_n, state_reg == ST_SUM, rd_cnt_reg <= s_win_reg)
    `DMAC_ASSERT_SAME(a_win_order, clk, rst_n, state_reg == ST_SUM, win_ok)
    // Position writes never reach the unused code.
    `DMAC_ASSERT_SAME(a_pos_code, clk, rst_n, ch_we, ch_wpos != POS_UNUSED)
    // A fresh order is only raised out of the decision step.
    `DMAC_ASSERT_NEXT(a_order_src, clk, rst_n, hold_empty, !order_valid_reg)

endmodule

FILE: rtl/dmac_hist_mem.sv
// Price history memory: one ring of MAX_WINDOW prices per instrument.
// Depends on dmac_pkg for width helpers.
`timescale 1ns / 1ps

module dmac_hist_mem #(
    parameter int NUM_INSTRUMENTS = dmac_pkg::DEF_NUM_INSTRUMENTS,
    parameter int MAX_WINDOW      = dmac_pkg::DEF_MAX_WINDOW
) (
    input  logic clk,
    input  logic we,
    input  logic [dmac_pkg::idx_width(NUM_INSTRUMENTS) + dmac_pkg::ptr_width(MAX_WINDOW) - 1:0]
                 waddr,
    input  logic [31:0] wdata,
    input  logic [dmac_pkg::idx_width(NUM_INSTRUMENTS) + dmac_pkg::ptr_width(MAX_WINDOW) - 1:0]
                 raddr,
    output logic [31:0] rdata
);
    import dmac_pkg::*;

    localparam int ADDR_W = idx_width(NUM_INSTRUMENTS) + ptr_width(MAX_WINDOW);
    localparam int DEPTH  = 2 ** ADDR_W;

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dmac_chan_tbl.sv
// Per-instrument channel state: fill count, write pointer and position.
// Depends on dmac_pkg; valid bits make unwritten entries read as zero.
`timescale 1ns / 1ps

module dmac_chan_tbl #(
    parameter int NUM_INSTRUMENTS = dmac_pkg::DEF_NUM_INSTRUMENTS,
    parameter int MAX_WINDOW      = dmac_pkg::DEF_MAX_WINDOW
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [dmac_pkg::idx_width(NUM_INSTRUMENTS)-1:0] rd_idx,
    output logic [dmac_pkg::win_width(MAX_WINDOW)-1:0]      rd_fill,
    output logic [dmac_pkg::ptr_width(MAX_WINDOW)-1:0]      rd_wp,
    output logic [1:0]                                      rd_pos,
    input  logic                                            wr_en,
    input  logic [dmac_pkg::idx_width(NUM_INSTRUMENTS)-1:0] wr_idx,
    input  logic [dmac_pkg::win_width(MAX_WINDOW)-1:0]      wr_fill,
    input  logic [dmac_pkg::ptr_width(MAX_WINDOW)-1:0]      wr_wp,
    input  logic [1:0]                                      wr_pos
);
    import dmac_pkg::*;

    localparam int WIN_W = win_width(MAX_WINDOW);
    localparam int PTR_W = ptr_width(MAX_WINDOW);
    localparam int ENT_W = WIN_W + PTR_W + 2;

    logic [ENT_W-1:0]           mem [NUM_INSTRUMENTS];
    logic [NUM_INSTRUMENTS-1:0] valid_reg;
    logic [ENT_W-1:0]           rd_data_reg;
    logic                       rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= {wr_fill, wr_wp, wr_pos};
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    // a never-written channel reads as empty and flat
    assign rd_fill = rd_valid_reg ? rd_data_reg[ENT_W-1 -: WIN_W] : '0;
    assign rd_wp   = rd_valid_reg ? rd_data_reg[PTR_W+1 -: PTR_W] : '0;
    assign rd_pos  = rd_valid_reg ? rd_data_reg[1:0] : POS_FLAT;

endmodule

FILE: rtl/dmac_arith.sv
// Shared arithmetic unit: one accumulating adder and one multiplier with compare.
// Depends on dmac_pkg for the control struct and width helpers.
`timescale 1ns / 1ps

module dmac_arith #(
    parameter int MAX_WINDOW = dmac_pkg::DEF_MAX_WINDOW
) (
    input  logic                                       clk,
    input  dmac_pkg::arith_ctrl_t                      ctrl,
    input  logic [31:0]                                price,
    input  logic [dmac_pkg::win_width(MAX_WINDOW)-1:0] f_win,
    input  logic [dmac_pkg::win_width(MAX_WINDOW)-1:0] s_win,
    output logic                                       fast_above,
    output logic                                       fast_below
);
    import dmac_pkg::*;

    localparam int WIN_W  = win_width(MAX_WINDOW);
    localparam int SUM_W  = 32 + WIN_W;
    localparam int PROD_W = SUM_W + WIN_W;

    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  acc_next;
    logic [SUM_W-1:0]  fast_reg;
    logic [PROD_W-1:0] lhs_reg;
    logic [PROD_W-1:0] rhs_reg;
    logic [SUM_W-1:0]  mul_a;
    logic [WIN_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;

    assign acc_next = acc_reg + SUM_W'(price);

    // fast_sum * S, then slow_sum * F through the same multiplier
    assign mul_a = ctrl.mul_fast ? fast_reg : acc_reg;
    assign mul_b = ctrl.mul_fast ? s_win : f_win;
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (ctrl.clr_acc)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.cap_fast)
        begin
            fast_reg <= acc_next;
        end
        if (ctrl.mul_fast)
        begin
            lhs_reg <= prod;
        end
        if (ctrl.mul_slow)
        begin
            rhs_reg <= prod;
        end
    end

    assign fast_above = lhs_reg > rhs_reg;
    assign fast_below = lhs_reg < rhs_reg;

endmodule

FILE: tb/dual_moving_average_crossover_test.sv
// Self-checking bench for dual_moving_average_crossover: bars go in, predicted orders are
// matched field by field. Depends on dmac_pkg and the RTL top level.
`timescale 1ns / 1ps

module dual_moving_average_crossover_test;
    import dmac_pkg::*;

    localparam int INSTS         = DEF_NUM_INSTRUMENTS;
    localparam int DEPTH         = DEF_MAX_WINDOW;
    localparam logic [1:0] REG_SPARE = 2'd3;   // no register behind this index
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 100;        // time for a full-window bar to finish
    localparam int STALL_LIMIT   = 4000;

    // Corner bars, run with F = 1, S = 2 and full slippage. Instrument 0 walks through
    // the fill stage, equal means, a saturated buy, a sell floored at zero and repeated
    // crossings that the position must block; instrument 15 tests the top of the range.
    localparam bar_t CORNER_BARS [15] = '{
        {4'd0,  32'h0000_0000}, {4'd0,  32'h0000_0000}, {4'd0,  32'hFFFF_FFFF},
        {4'd0,  32'hFFFF_FFFF}, {4'd0,  32'h0000_0000}, {4'd0,  32'h0000_0000},
        {4'd0,  32'd5},         {4'd0,  32'd70000},     {4'd0,  32'd3},
        {4'd0,  32'd1},         {4'd15, 32'hFFFF_FFFF}, {4'd15, 32'hFFFF_FFFE},
        {4'd15, 32'hFFFF_FFFF}, {4'd15, 32'h0000_0000}, {4'd15, 32'h0000_0000}
    };

    // Predicts the orders of the block and holds those still due.
    class crossover_book;
        logic [31:0] history [INSTS][DEPTH];
        int unsigned held [INSTS];
        logic [5:0]  head [INSTS];
        logic [1:0]  pos [INSTS];
        logic [5:0]  fast_reg;
        logic [6:0]  slow_reg;
        logic [15:0] slip_reg;
        order_t      due_orders [$];
        int          errors;

        function new();
            fast_reg = FAST_WINDOW_RESET;
            slow_reg = SLOW_WINDOW_RESET;
            slip_reg = SLIPPAGE_RESET;
            errors = 0;
            for (int i = 0; i < INSTS; i++) begin
                held[i] = 0;
                head[i] = '0;
                pos[i] = POS_FLAT;
                for (int j = 0; j < DEPTH; j++)
                    history[i][j] = '0;
            end
        endfunction

        function void write_reg(input logic [1:0] addr, input logic [15:0] data);
            case (addr)
                REG_FAST_WINDOW: fast_reg = data[5:0];
                REG_SLOW_WINDOW: slow_reg = data[6:0];
                REG_SLIPPAGE:    slip_reg = data;
                default: ;
            endcase
        endfunction

        function logic [63:0] newest_sum(input int ch, input int n);
            logic [63:0] acc;
            logic [5:0]  slot;
            acc = '0;
            for (int i = 0; i < n; i++) begin
                slot = head[ch] - 6'd1 - i[5:0];
                acc += 64'(history[ch][slot]);
            end
            return acc;
        endfunction

        function void take_bar(input bar_t b);
            int          ch;
            int          f;
            int          s;
            logic [63:0] fast_side;
            logic [63:0] slow_side;
            logic [32:0] raised;
            order_t      o;
            ch = int'(b.instrument);
            history[ch][head[ch]] = b.close_price;
            head[ch] = head[ch] + 6'd1;
            if (held[ch] < DEPTH)
                held[ch]++;
            f = (fast_reg == 6'd0) ? 1 : int'(fast_reg);
            s = (int'(slow_reg) < f) ? f + 1 : int'(slow_reg);
            if (s > DEPTH)
                s = DEPTH;
            if (f > s)
                f = s;
            if (held[ch] < s)
                return;
            fast_side = newest_sum(ch, f) * 64'(s);
            slow_side = newest_sum(ch, s) * 64'(f);
            o.order_instrument = b.instrument;
            if (fast_side > slow_side && pos[ch] != POS_LONG) begin
                raised = {1'b0, b.close_price} + {17'd0, slip_reg};
                o.side = SIDE_BUY;
                o.limit_price = raised[32] ? 32'hFFFF_FFFF : raised[31:0];
                pos[ch] = (pos[ch] == POS_SHORT) ? POS_FLAT : POS_LONG;
                due_orders = {due_orders, o};
            end else if (fast_side < slow_side && pos[ch] != POS_SHORT) begin
                o.side = SIDE_SELL;
                o.limit_price = (b.close_price >= 32'(slip_reg))
                              ? b.close_price - 32'(slip_reg) : '0;
                pos[ch] = (pos[ch] == POS_LONG) ? POS_FLAT : POS_SHORT;
                due_orders = {due_orders, o};
            end
        endfunction

        function void match_order(input order_t got);
            order_t want;
            if (due_orders.size() == 0) begin
                $display("%0t: unexpected order, expected none, got inst %0d side %0d price %0h",
                         $time, got.order_instrument, got.side, got.limit_price);
                errors++;
                return;
            end
            want = due_orders[0];
            due_orders.delete(0);
            if (got.order_instrument !== want.order_instrument) begin
                $display("%0t: order_instrument mismatch, expected %0d, got %0d",
                         $time, want.order_instrument, got.order_instrument);
                errors++;
            end
            if (got.side !== want.side) begin
                $display("%0t: side mismatch, expected %0d, got %0d",
                         $time, want.side, got.side);
                errors++;
            end
            if (got.limit_price !== want.limit_price) begin
                $display("%0t: limit_price mismatch, expected %0h, got %0h",
                         $time, want.limit_price, got.limit_price);
                errors++;
            end
        endfunction

        function int pending();
            return due_orders.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        bar_valid = 1'b0;
    logic        bar_ready;
    bar_t        bar = '0;
    logic        order_valid;
    logic        order_ready = 1'b0;
    order_t      order;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = REG_FAST_WINDOW;
    logic [15:0] cfg_wdata = '0;

    logic        calm = 1'b0;           // high: neither side idles
    int          quiet_cycles = 0;
    logic [31:0] last_px [INSTS];
    logic        drift_up [INSTS];
    crossover_book book;

    dual_moving_average_crossover uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .bar_valid   (bar_valid),
        .bar_ready   (bar_ready),
        .bar         (bar),
        .order_valid (order_valid),
        .order_ready (order_ready),
        .order       (order),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Order side: stall about one cycle in six, except during the calm stretch.
    always @(posedge clk)
        order_ready <= calm || ($urandom_range(0, 99) >= 16);

    // Sample handshakes at the falling edge: every driven signal settled at the rising one.
    always @(negedge clk)
    begin
        if (rst_n && order_valid && order_ready)
            book.match_order(order);
    end

    // Count cycles in which no request moves on either channel.
    always @(negedge clk)
    begin
        if ((bar_valid && bar_ready) || (order_valid && order_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Hold one register write for a cycle and mirror it into the predictor.
    task automatic put_reg(input logic [1:0] addr, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        book.write_reg(addr, data);
    endtask

    // Load all three registers, then hit the unused index with data that would
    // corrupt the slippage if the decode aliased it.
    task automatic load_settings(input logic [5:0] f, input logic [6:0] s,
                                 input logic [15:0] slip);
        put_reg(REG_FAST_WINDOW, {10'd0, f});
        put_reg(REG_SLOW_WINDOW, {9'd0, s});
        put_reg(REG_SLIPPAGE, slip);
        put_reg(REG_SPARE, ~slip);
        cfg_we <= 1'b0;
    endtask

    // Present one bar request and hold it until accepted; return just after that edge.
    task automatic push_bar(input bar_t b);
        bar <= b;
        bar_valid <= 1'b1;
        @(negedge clk);
        while (!bar_ready)
            @(negedge clk);
        book.take_bar(b);
        @(posedge clk);
    endtask

    // Wait for every predicted order, then give the block time to finish a bar
    // that produces none.
    task automatic settle();
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly a trending walk per instrument so the averages cross often; the rest
    // is noise and the range extremes.
    function automatic logic [31:0] next_price(input int ch);
        int pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 11) == 0)
            drift_up[ch] = ~drift_up[ch];
        if (pick < 80) begin
            if (drift_up[ch])
                last_px[ch] = last_px[ch] + $urandom_range(0, 1000);
            else
                last_px[ch] = last_px[ch] - $urandom_range(0, 1000);
            last_px[ch] = last_px[ch] + $urandom_range(0, 200) - 32'd100;
            return last_px[ch];
        end
        else if (pick < 88)
            return $urandom;
        else if (pick < 94)
            return 32'h0000_0000;
        else
            return 32'hFFFF_FFFF;
    endfunction

    // One setting of the registers: draw bars from a random group of instruments
    // of the given size, with random gaps and an occasional full drain.
    task automatic run_phase(input logic [5:0] f, input logic [6:0] s, input logic [15:0] slip,
                             input int lanes, input int count, input logic quiet);
        logic [3:0] mask;
        bar_t       b;
        int         gap;
        mask = 4'($urandom_range(0, 15));
        calm <= quiet;
        load_settings(f, s, slip);
        for (int k = 0; k < count; k++) begin
            b.instrument = mask ^ 4'($urandom_range(0, lanes - 1));
            b.close_price = next_price(int'(b.instrument));
            if (!quiet && $urandom_range(0, 99) < 16) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                  : $urandom_range(1, 6);
                bar_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 149) == 0) begin
                // hold off until the block has delivered everything owed
                bar_valid <= 1'b0;
                @(posedge clk);
                while (book.pending() != 0)
                    @(posedge clk);
            end
            push_bar(b);
        end
        bar_valid <= 1'b0;
        settle();
    endtask

    initial
    begin
        book = new();
        for (int i = 0; i < INSTS; i++) begin
            last_px[i] = $urandom;
            drift_up[i] = 1'($urandom_range(0, 1));
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner bars: fast window 0 acts as 1, slow window 2, full slippage.
        load_settings(6'd0, 7'd2, 16'hFFFF);
        for (int i = 0; i < 15; i++)
            push_bar(CORNER_BARS[i]);
        bar_valid <= 1'b0;
        settle();

        run_phase(6'd5,  7'd20, 16'd0,     4,  180, 1'b0);  // register defaults
        run_phase(6'd0,  7'd1,  16'd1,     3,  30,  1'b0);  // one-bar windows: means tie
        run_phase(6'd63, 7'd64, 16'hFFFF,  2,  200, 1'b0);  // widest windows
        run_phase(6'd10, 7'd3,  16'd250,   6,  150, 1'b0);  // slow below fast: S = F + 1
        run_phase(6'd2,  7'd8,  16'h8000,  16, 250, 1'b1);  // no idling on either side
        run_phase(6'd40, 7'd2,  16'd7,     1,  100, 1'b0);
        run_phase(6'd0,  7'd3,  16'd0,     16, 150, 1'b0);
        run_phase(6'd3,  7'd64, 16'h5A5A,  2,  120, 1'b0);

        if (book.errors == 0 && book.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
